@@ design/bgls_pkg.sv @@
// Package for the bar-graph LED matrix serializer: word types, register
// indexes, frame constants and the per-level colour table.
// No dependencies.
package bgls_pkg;

	localparam int LED_COUNT    = 64;
	localparam int BITS_PER_LED = 24;
	localparam int PIX_W        = $clog2(LED_COUNT);
	localparam int BIT_W        = $clog2(BITS_PER_LED);
	localparam int TICK_W       = 16;
	localparam int HEIGHT_W     = 4;
	localparam int COLOUR_W     = 24;
	localparam int CFG_IDX_W    = 3;

	localparam logic [BIT_W-1:0] LAST_BIT = BIT_W'(BITS_PER_LED - 1);
	localparam logic [PIX_W-1:0] LAST_PIX = PIX_W'(LED_COUNT - 1);

	// Register indexes on the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_ONE_HIGH  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ONE_LOW   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ZERO_HIGH = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ZERO_LOW  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_LATCH     = 3'd4;

	localparam logic [TICK_W-1:0] RST_ONE_HIGH  = 16'd28;
	localparam logic [TICK_W-1:0] RST_ONE_LOW   = 16'd12;
	localparam logic [TICK_W-1:0] RST_ZERO_HIGH = 16'd12;
	localparam logic [TICK_W-1:0] RST_ZERO_LOW  = 16'd28;
	localparam logic [TICK_W-1:0] RST_LATCH     = 16'd6000;

	typedef enum logic [1:0] {
		PH_IDLE  = 2'd0,
		PH_HIGH  = 2'd1,
		PH_LOW   = 2'd2,
		PH_LATCH = 2'd3
	} phase_t;

	typedef struct packed {
		logic                mode;
		logic [HEIGHT_W-1:0] height_col0;
		logic [HEIGHT_W-1:0] height_col1;
		logic [HEIGHT_W-1:0] height_col2;
		logic [HEIGHT_W-1:0] height_col3;
		logic [HEIGHT_W-1:0] height_col4;
		logic [HEIGHT_W-1:0] height_col5;
		logic [HEIGHT_W-1:0] height_col6;
		logic [HEIGHT_W-1:0] height_col7;
	} item_t;

	typedef struct packed {
		logic pin;
		logic busy_res;
		logic load_accepted;
		logic frame_done;
	} result_t;

	typedef logic [7:0][HEIGHT_W-1:0] heights_t;

	typedef struct packed {
		logic [TICK_W-1:0] one_high;
		logic [TICK_W-1:0] one_low;
		logic [TICK_W-1:0] zero_high;
		logic [TICK_W-1:0] zero_low;
		logic [TICK_W-1:0] latch;
	} timing_t;

	// GRB colour of a lit pixel on a given level (1 = bottom row)
	function automatic logic [COLOUR_W-1:0] level_colour(input logic [HEIGHT_W-1:0] level);
		logic [COLOUR_W-1:0] c;
		case (level)
			4'd1:    c = 24'h00FF00;
			4'd2:    c = 24'h20B000;
			4'd3:    c = 24'h308000;
			4'd4:    c = 24'h404000;
			4'd5:    c = 24'h800000;
			4'd6:    c = 24'hB00040;
			4'd7:    c = 24'h000080;
			4'd8:    c = 24'h0000B0;
			default: c = 24'h000000;
		endcase
		return c;
	endfunction

endpackage

@@ design/bar_graph_led_matrix_serializer_core.sv @@
// Top level of the bar-graph LED matrix serializer: word handshakes and the
// result register. Depends on bgls_pkg and bgls_seq.
//
//  channel  | handshake                   | payload
//  ---------+-----------------------------+---------------------------------
//  item     | item_valid / item_ready     | item (mode, height_col0..7)
//  result   | result_valid / result_ready | result (pin, busy_res, ...)
//  config   | cfg_we                      | cfg_index, cfg_wdata (16 bits)
//
// One word per clock: a word is accepted, its state update and result are
// computed in the same cycle and the result is registered for the next.
// The result register is refilled in the cycle it is drained, so item_ready
// stays high while result_ready is high; a stalled result holds off one word.
// arst_n clears the frame state and the result valid flag and loads the
// register reset values.
module bar_graph_led_matrix_serializer_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              item_valid,
	output logic                              item_ready,
	input  bgls_pkg::item_t                   item,
	output logic                              result_valid,
	input  logic                              result_ready,
	output bgls_pkg::result_t                 result,
	input  logic                              cfg_we,
	input  logic [bgls_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [bgls_pkg::TICK_W-1:0]       cfg_wdata
);

	logic              fire;
	logic              result_valid_q;
	bgls_pkg::result_t result_q;
	bgls_pkg::result_t result_d;

	assign item_ready   = !result_valid_q || result_ready;
	assign fire         = item_valid && item_ready;
	assign result_valid = result_valid_q;
	assign result       = result_q;

	bgls_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (fire),
		.item      (item),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.result_d  (result_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (item_ready) begin
			result_valid_q <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			result_q <= result_d;
		end
	end

	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid_q && !result_ready |=> result_valid_q && $stable(result_q))
		else $error("result word changed while stalled");

	a_ready_follows: assert property (@(posedge clk) disable iff (!arst_n)
		!result_valid_q |-> item_ready)
		else $error("input blocked with empty result register");

	a_fill: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> result_valid_q)
		else $error("accepted word produced no result");

endmodule

@@ design/bgls_bit_sel.sv @@
// Data bit lookup: picks the current waveform bit from the latched column
// heights, the pixel index and the bit index. Depends on bgls_pkg.
module bgls_bit_sel (
	input  bgls_pkg::heights_t               heights,
	input  logic [bgls_pkg::PIX_W-1:0]       pixel_index,
	input  logic [bgls_pkg::BIT_W-1:0]       bit_index,
	output logic                             data_bit
);

	logic [bgls_pkg::HEIGHT_W-1:0] col_height;
	logic [bgls_pkg::HEIGHT_W-1:0] level;
	logic [bgls_pkg::COLOUR_W-1:0] colour;

	always_comb begin
		col_height = heights[pixel_index[2:0]];
		// row 0 of the chain is the top of the bar
		level      = 4'd8 - {1'b0, pixel_index[5:3]};
		colour     = (level <= col_height) ? bgls_pkg::level_colour(level) : '0;
		data_bit   = (bit_index <= bgls_pkg::LAST_BIT) ? colour[bit_index] : 1'b0;
	end

endmodule

@@ design/bgls_seq.sv @@
// Waveform sequencer: timing registers, frame state and the next-state and
// result logic for one word. Depends on bgls_pkg and bgls_bit_sel.
module bgls_seq (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              fire,
	input  bgls_pkg::item_t                   item,
	input  logic                              cfg_we,
	input  logic [bgls_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [bgls_pkg::TICK_W-1:0]       cfg_wdata,
	output bgls_pkg::result_t                 result_d
);

	bgls_pkg::timing_t                timing_q;
	bgls_pkg::heights_t               heights_q, heights_d;
	bgls_pkg::phase_t                 phase_q, phase_d;
	logic [bgls_pkg::PIX_W-1:0]       pixel_q, pixel_d;
	logic [bgls_pkg::BIT_W-1:0]       bit_q, bit_d;
	logic [bgls_pkg::TICK_W-1:0]      tick_q, tick_d;
	logic                             data_bit;
	logic [bgls_pkg::TICK_W-1:0]      period_len;
	logic                             period_end;

	bgls_bit_sel u_bit_sel (
		.heights     (heights_q),
		.pixel_index (pixel_q),
		.bit_index   (bit_q),
		.data_bit    (data_bit)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timing_q.one_high  <= bgls_pkg::RST_ONE_HIGH;
			timing_q.one_low   <= bgls_pkg::RST_ONE_LOW;
			timing_q.zero_high <= bgls_pkg::RST_ZERO_HIGH;
			timing_q.zero_low  <= bgls_pkg::RST_ZERO_LOW;
			timing_q.latch     <= bgls_pkg::RST_LATCH;
		end else if (cfg_we) begin
			unique case (cfg_index)
				bgls_pkg::REG_ONE_HIGH:  timing_q.one_high  <= cfg_wdata;
				bgls_pkg::REG_ONE_LOW:   timing_q.one_low   <= cfg_wdata;
				bgls_pkg::REG_ZERO_HIGH: timing_q.zero_high <= cfg_wdata;
				bgls_pkg::REG_ZERO_LOW:  timing_q.zero_low  <= cfg_wdata;
				bgls_pkg::REG_LATCH:     timing_q.latch     <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			heights_q <= '0;
			phase_q   <= bgls_pkg::PH_IDLE;
			pixel_q   <= '0;
			bit_q     <= bgls_pkg::LAST_BIT;
			tick_q    <= '0;
		end else if (fire) begin
			heights_q <= heights_d;
			phase_q   <= phase_d;
			pixel_q   <= pixel_d;
			bit_q     <= bit_d;
			tick_q    <= tick_d;
		end
	end

	always_comb begin
		unique case (phase_q)
			bgls_pkg::PH_HIGH:  period_len = data_bit ? timing_q.one_high : timing_q.zero_high;
			bgls_pkg::PH_LOW:   period_len = data_bit ? timing_q.one_low : timing_q.zero_low;
			bgls_pkg::PH_LATCH: period_len = timing_q.latch;
			default:            period_len = timing_q.latch;
		endcase
		// a zero length behaves as one tick
		period_end = ({1'b0, tick_q} + 17'd1) >= {1'b0, period_len};
	end

	always_comb begin
		heights_d = heights_q;
		phase_d   = phase_q;
		pixel_d   = pixel_q;
		bit_d     = bit_q;
		tick_d    = period_end ? '0 : tick_q + 16'd1;
		result_d  = '0;
		if (item.mode) begin
			tick_d            = tick_q;
			result_d.busy_res = 1'b1;
			if (phase_q == bgls_pkg::PH_IDLE) begin
				heights_d = {item.height_col7, item.height_col6, item.height_col5,
					item.height_col4, item.height_col3, item.height_col2,
					item.height_col1, item.height_col0};
				pixel_d   = '0;
				bit_d     = bgls_pkg::LAST_BIT;
				tick_d    = '0;
				phase_d   = bgls_pkg::PH_HIGH;
				result_d.load_accepted = 1'b1;
			end else begin
				// refuse the load, report the line level
				result_d.pin = (phase_q == bgls_pkg::PH_HIGH);
			end
		end else begin
			unique case (phase_q)
				bgls_pkg::PH_IDLE: begin
					tick_d = tick_q;
				end
				bgls_pkg::PH_HIGH: begin
					result_d.pin      = 1'b1;
					result_d.busy_res = 1'b1;
					if (period_end) phase_d = bgls_pkg::PH_LOW;
				end
				bgls_pkg::PH_LOW: begin
					result_d.busy_res = 1'b1;
					if (period_end) begin
						if (bit_q == '0 || bit_q > bgls_pkg::LAST_BIT) begin
							bit_d = bgls_pkg::LAST_BIT;
							if (pixel_q == bgls_pkg::LAST_PIX) begin
								pixel_d = '0;
								phase_d = bgls_pkg::PH_LATCH;
							end else begin
								pixel_d = pixel_q + 1'b1;
								phase_d = bgls_pkg::PH_HIGH;
							end
						end else begin
							bit_d   = bit_q - 1'b1;
							phase_d = bgls_pkg::PH_HIGH;
						end
					end
				end
				bgls_pkg::PH_LATCH: begin
					result_d.busy_res = 1'b1;
					if (period_end) begin
						phase_d             = bgls_pkg::PH_IDLE;
						result_d.frame_done = 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	a_bit_range: assert property (@(posedge clk) disable iff (!arst_n)
		bit_q <= bgls_pkg::LAST_BIT)
		else $error("bit index out of range");

	a_idle_clean: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == bgls_pkg::PH_IDLE |-> (tick_q == '0 && pixel_q == '0
			&& bit_q == bgls_pkg::LAST_BIT))
		else $error("idle with frame counters not cleared");

	a_load_only_idle: assert property (@(posedge clk) disable iff (!arst_n)
		fire && result_d.load_accepted |=> phase_q == bgls_pkg::PH_HIGH && tick_q == '0)
		else $error("accepted load did not start a frame");

	a_done_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		fire && result_d.frame_done |=> phase_q == bgls_pkg::PH_IDLE)
		else $error("frame done without returning to idle");

	a_latch_entry: assert property (@(posedge clk) disable iff (!arst_n)
		fire && phase_q == bgls_pkg::PH_LOW && phase_d == bgls_pkg::PH_LATCH
		|-> pixel_q == bgls_pkg::LAST_PIX && bit_q == '0)
		else $error("latch period entered before the last bit");

endmodule

@@ dv/bgls_line_monitor.sv @@
// Monitor for the bar-graph serializer: follows the register port, predicts
// the data line word by word and compares each result word in order.
// Depends on bgls_pkg.
module bgls_line_monitor
	import bgls_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 item_valid,
	input  logic                 item_ready,
	input  item_t                item,
	input  logic                 result_valid,
	input  logic                 result_ready,
	input  result_t              result,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [TICK_W-1:0]    cfg_wdata,
	output int                   mismatches,
	output int                   words_due
);
	timeunit 1ns;
	timeprecision 1ps;

	heights_t          bar_h;
	logic [PIX_W-1:0]  led;
	logic [BIT_W-1:0]  bit_pos;
	phase_t            line_ph;
	logic [TICK_W-1:0] ticks;
	timing_t           timing;
	result_t           line_words[$];

	function automatic logic [COLOUR_W-1:0] grb_for(input logic [HEIGHT_W-1:0] level);
		logic [COLOUR_W-1:0] grb;
		case (level)
			4'd8:    grb = 24'h0000B0;
			4'd7:    grb = 24'h000080;
			4'd6:    grb = 24'hB00040;
			4'd5:    grb = 24'h800000;
			4'd4:    grb = 24'h404000;
			4'd3:    grb = 24'h308000;
			4'd2:    grb = 24'h20B000;
			4'd1:    grb = 24'h00FF00;
			default: grb = 24'h000000;
		endcase
		return grb;
	endfunction

	// Bit b of LED k: row from the top of the matrix, column from the low bits
	function automatic logic led_bit(input heights_t h, input logic [PIX_W-1:0] k,
			input logic [BIT_W-1:0] b);
		logic [HEIGHT_W-1:0] level;
		logic [COLOUR_W-1:0] grb;
		level = HEIGHT_W'(8) - HEIGHT_W'(k[PIX_W-1:3]);
		grb = (level <= h[k[2:0]]) ? grb_for(level) : '0;
		return (b < BIT_W'(COLOUR_W)) ? grb[b] : 1'b0;
	endfunction

	// A length of zero still lasts one tick
	function automatic logic period_over(input logic [TICK_W-1:0] cnt,
			input logic [TICK_W-1:0] len);
		return ({1'b0, cnt} + 1'b1) >= {1'b0, len};
	endfunction

	task automatic advance_line(input item_t w, output result_t r);
		logic one;
		r = '0;
		one = led_bit(bar_h, led, bit_pos);
		if (w.mode) begin
			if (line_ph == PH_IDLE) begin
				bar_h[0] = w.height_col0;
				bar_h[1] = w.height_col1;
				bar_h[2] = w.height_col2;
				bar_h[3] = w.height_col3;
				bar_h[4] = w.height_col4;
				bar_h[5] = w.height_col5;
				bar_h[6] = w.height_col6;
				bar_h[7] = w.height_col7;
				led = '0;
				bit_pos = LAST_BIT;
				ticks = '0;
				line_ph = PH_HIGH;
				r.load_accepted = 1'b1;
			end else begin
				// refused: show the line, hold the waveform
				r.pin = (line_ph == PH_HIGH);
			end
			r.busy_res = 1'b1;
		end else begin
			case (line_ph)
				PH_HIGH: begin
					r.pin = 1'b1;
					r.busy_res = 1'b1;
					if (period_over(ticks, one ? timing.one_high : timing.zero_high)) begin
						ticks = '0;
						line_ph = PH_LOW;
					end else begin
						ticks++;
					end
				end
				PH_LOW: begin
					r.busy_res = 1'b1;
					if (period_over(ticks, one ? timing.one_low : timing.zero_low)) begin
						ticks = '0;
						if (bit_pos == '0 || bit_pos > LAST_BIT) begin
							bit_pos = LAST_BIT;
							if (led == LAST_PIX) begin
								led = '0;
								line_ph = PH_LATCH;
							end else begin
								led++;
								line_ph = PH_HIGH;
							end
						end else begin
							bit_pos--;
							line_ph = PH_HIGH;
						end
					end else begin
						ticks++;
					end
				end
				PH_LATCH: begin
					r.busy_res = 1'b1;
					if (period_over(ticks, timing.latch)) begin
						ticks = '0;
						line_ph = PH_IDLE;
						r.frame_done = 1'b1;
					end else begin
						ticks++;
					end
				end
				default: ;
			endcase
		end
	endtask

	function automatic int flag_field(input string name, input logic want, input logic got);
		if (want !== got) begin
			$error("%s: expected %0b, got %0b", name, want, got);
			return 1;
		end
		return 0;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			bar_h = '0;
			led = '0;
			bit_pos = LAST_BIT;
			line_ph = PH_IDLE;
			ticks = '0;
			timing = '{RST_ONE_HIGH, RST_ONE_LOW, RST_ZERO_HIGH, RST_ZERO_LOW, RST_LATCH};
			line_words.delete();
			mismatches = 0;
			words_due = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_ONE_HIGH:  timing.one_high = cfg_wdata;
					REG_ONE_LOW:   timing.one_low = cfg_wdata;
					REG_ZERO_HIGH: timing.zero_high = cfg_wdata;
					REG_ZERO_LOW:  timing.zero_low = cfg_wdata;
					REG_LATCH:     timing.latch = cfg_wdata;
					default: ;
				endcase
			end
			// compare before queuing: a result word is registered after its item
			if (result_valid && result_ready) begin
				if (line_words.size() == 0) begin
					$error("result word %p arrived with none expected", result);
					mismatches++;
				end else begin
					want = line_words.pop_front();
					mismatches += flag_field("pin", want.pin, result.pin)
						+ flag_field("busy_res", want.busy_res, result.busy_res)
						+ flag_field("load_accepted", want.load_accepted, result.load_accepted)
						+ flag_field("frame_done", want.frame_done, result.frame_done);
				end
			end
			if (item_valid && item_ready) begin
				advance_line(item, want);
				line_words.push_back(want);
			end
			words_due = line_words.size();
		end
	end

endmodule

@@ dv/bar_graph_led_matrix_serializer_core_tb.sv @@
// Testbench top for bar_graph_led_matrix_serializer_core: clock, reset,
// register writes, item and result traffic with random gaps, and the verdict.
// Depends on bgls_pkg, the core and bgls_line_monitor.
module bar_graph_led_matrix_serializer_core_tb
	import bgls_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 2_000_000;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 item_valid = 1'b0;
	logic                 item_ready;
	item_t                item = '0;
	logic                 result_valid;
	logic                 result_ready = 1'b0;
	result_t              result;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [TICK_W-1:0]    cfg_wdata = '0;
	int                   mismatches;
	int                   words_due;
	int                   n_sent = 0;
	int                   n_recv = 0;
	bit                   calm = 1'b0;
	int                   cycles = 0;

	bar_graph_led_matrix_serializer_core u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata)
	);

	bgls_line_monitor u_line_monitor (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata),
		.mismatches   (mismatches),
		.words_due    (words_due)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// Alternate stretches without idling and stretches with random gaps
	always begin
		calm = ($urandom_range(0, 3) == 0);
		repeat ($urandom_range(50, 400)) @(posedge clk);
	end

	function automatic int draw_wait();
		return calm ? 0 : int'($urandom_range(0, 6));
	endfunction

	function automatic heights_t rand_heights(input bit wide);
		heights_t h;
		for (int c = 0; c < 8; c++)
			h[c] = (wide || $urandom_range(0, 6) == 0) ? HEIGHT_W'($urandom_range(0, 15))
				: HEIGHT_W'($urandom_range(0, 8));
		return h;
	endfunction

	function automatic item_t make_word(input logic load, input heights_t h);
		item_t w;
		w.mode = load;
		w.height_col0 = h[0];
		w.height_col1 = h[1];
		w.height_col2 = h[2];
		w.height_col3 = h[3];
		w.height_col4 = h[4];
		w.height_col5 = h[5];
		w.height_col6 = h[6];
		w.height_col7 = h[7];
		return w;
	endfunction

	// Mostly ticks; a noisy stream adds the odd load that a busy block refuses
	function automatic item_t next_tick(input bit noisy);
		return make_word(noisy && $urandom_range(0, 24) == 0, rand_heights(1'b1));
	endfunction

	task automatic send_word(input item_t w);
		int gap;
		gap = draw_wait();
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_valid <= 1'b1;
		item <= w;
		do @(posedge clk); while (!item_ready);
		n_sent++;
	endtask

	task automatic send_ticks(input int count);
		repeat (count) send_word(next_tick(1'b1));
	endtask

	// Wait until every accepted word has come back
	task automatic drain();
		while (n_recv != n_sent) @(posedge clk);
	endtask

	task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [TICK_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
	endtask

	task automatic program_timing(input timing_t t);
		put_reg(REG_ONE_HIGH, t.one_high);
		put_reg(REG_ONE_LOW, t.one_low);
		put_reg(REG_ZERO_HIGH, t.zero_high);
		put_reg(REG_ZERO_LOW, t.zero_low);
		put_reg(REG_LATCH, t.latch);
		// indexes past the register list must be dropped
		for (int i = REG_LATCH + 1; i < (1 << CFG_IDX_W); i++)
			put_reg(CFG_IDX_W'(i), TICK_W'($urandom));
		cfg_we <= 1'b0;
	endtask

	initial begin : line_sink
		int stall;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			// long hold now and then so the block fills and stalls its input
			stall = (n_recv % 5000 == 150) ? 90 : draw_wait();
			if (stall > 0) begin
				result_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			result_ready <= 1'b1;
			do @(posedge clk); while (!result_valid);
			n_recv++;
		end
	end

	initial begin : stimulus
		heights_t mixed;
		mixed = {4'd12, 4'd4, 4'd7, 4'd1, 4'd9, 4'd15, 4'd0, 4'd8};
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// ticks while idle, heights don't matter
		send_word(make_word(1'b0, '1));
		send_word(make_word(1'b0, '0));
		item_valid <= 1'b0;
		drain();

		program_timing(timing_t'{16'd2, 16'd1, 16'd1, 16'd2, 16'd3});
		// heights at both ends and above eight, then loads refused in both line phases
		send_word(make_word(1'b1, mixed));
		for (int i = 0; i < 20; i++) begin
			if (i == 7)
				send_word(make_word(1'b1, '0));
			else if (i % 5 == 2)
				send_word(make_word(1'b1, '1));
			else
				send_word(make_word(1'b0, rand_heights(1'b1)));
		end
		send_ticks(180);
		item_valid <= 1'b0;
		drain();

		// new counts take effect mid-frame, also on periods already past them
		program_timing(timing_t'{16'd1, 16'd1, 16'd1, 16'd1, 16'd1});
		send_ticks(150);
		item_valid <= 1'b0;
		drain();

		// zero counts behave as one tick
		program_timing('0);
		send_ticks(100);
		item_valid <= 1'b0;
		drain();

		program_timing(timing_t'{16'd3, 16'd2, 16'd2, 16'd3, 16'd50});
		send_ticks(150);
		item_valid <= 1'b0;
		drain();

		// longest counts everywhere: the line holds in one period
		program_timing('1);
		send_ticks(150);
		item_valid <= 1'b0;

		drain();
		repeat (16) @(posedge clk);
		if (mismatches == 0 && words_due == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
